// File: hdl/assert_macros.svh
// Assertion macros shared by the trial tracker RTL.
// Depends on nothing; every macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: hdl/srtt_pkg.sv
// Package for the stimulus/response trial tracker: widths, payload types,
// configuration register indexes and a saturating count helper. No dependencies.
package srtt_pkg;

  localparam int TIME_W            = 32;
  localparam int CNT_W             = 8;
  localparam int CLASS_W           = 8;
  localparam int MIN_PATTERN_STIMS = 4;
  localparam int Q_DEPTH           = 2;
  localparam int Q_PTR_W           = $clog2(Q_DEPTH);
  localparam int Q_CNT_W           = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX          = '1;
  localparam logic [TIME_W-1:0] POST_WINDOW_RST  = TIME_W'(500000);
  localparam logic [TIME_W-1:0] LATE_WINDOW_RST  = TIME_W'(1500000);
  localparam logic [CLASS_W-1:0] CLASS_RST       = CLASS_W'(1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 2'd0,
    REG_POST_WINDOW = 2'd1,
    REG_LATE_WINDOW = 2'd2,
    REG_STOP_NEW    = 2'd3
  } reg_idx_e;

  // One input sample.
  typedef struct packed {
    logic [TIME_W-1:0]  timestamp;
    logic               stim_level;
    logic               neuron_level;
    logic [CLASS_W-1:0] class_id;
  } in_t;

  // One closed-trial record.
  typedef struct packed {
    logic [CNT_W-1:0]   n_spikes;
    logic               fired_in_window;
    logic               fired_late;
    logic [CLASS_W-1:0] label;
    logic [CNT_W-1:0]   n_stims;
    logic [TIME_W-1:0]  closed_time;
  } out_t;

  // A classified sample as it travels from the front end to the back end.
  typedef struct packed {
    logic [TIME_W-1:0]  timestamp;
    logic               stim_rise;
    logic               neuron_level;
    logic [CLASS_W-1:0] class_id;
  } item_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [TIME_W-1:0] post_window;
    logic [TIME_W-1:0] late_window;
    logic              stop_new_trials;
  } cfg_t;

  // Queue status toward the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == CNT_MAX) ? v : v + CNT_W'(1);
    return r;
  endfunction

endpackage

// File: hdl/srtt_front.sv
// Front end of the trial tracker: takes sample transfers and detects stimulus edges.
// Depends on srtt_pkg.
module srtt_front import srtt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    enable_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  in_t     in_data_i,
  input  q_stat_t q_stat_i,
  output logic    push_o,
  output item_t   push_item_o
);

  logic prev_stim_q, prev_stim_d;
  logic take;

  // A sample is taken whenever the queue has room; disabled samples are dropped.
  assign in_ready_o = !q_stat_i.full;
  assign take       = in_valid_i && in_ready_o && enable_i;
  assign push_o     = take;

  // Classify the sample for the back end.
  always_comb begin
    push_item_o.timestamp    = in_data_i.timestamp;
    push_item_o.stim_rise    = !prev_stim_q && in_data_i.stim_level;
    push_item_o.neuron_level = in_data_i.neuron_level;
    push_item_o.class_id     = in_data_i.class_id;
  end

  // The stimulus line history moves only on enabled samples.
  assign prev_stim_d = take ? in_data_i.stim_level : prev_stim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_stim_q <= 1'b0;
    end else begin
      prev_stim_q <= prev_stim_d;
    end
  end

endmodule

// File: hdl/srtt_queue.sv
// Short queue between the front end and the back end of the trial tracker.
// Depends on srtt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srtt_queue import srtt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   push_item_i,
  input  logic    pop_i,
  output item_t   head_o,
  output q_stat_t stat_o
);

  item_t                slots_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   count_q, count_d;

  assign stat_o.full  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = slots_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + Q_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && stat_o.full && !pop_i, "queue push while full")
  `ASSERT_NEVER(a_no_underflow, pop_i && stat_o.empty, "queue pop while empty")
  `ASSERT_CLK(a_count_bound, count_q <= Q_CNT_W'(Q_DEPTH), "queue count out of range")

endmodule

// File: hdl/srtt_back.sv
// Back end of the trial tracker: trial state, response classification and the
// output record register. Depends on srtt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srtt_back import srtt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   head_i,
  input  q_stat_t q_stat_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output out_t    out_data_o
);

  // Trial state.
  logic               open_q, open_d;
  logic               wover_q, wover_d;
  logic               hit_q, hit_d;
  logic               late_q, late_d;
  logic               prev_n_q, prev_n_d;
  logic [TIME_W-1:0]  last_q, last_d;
  logic [CNT_W-1:0]   stims_q, stims_d;
  logic [CNT_W-1:0]   spikes_q, spikes_d;
  logic [CLASS_W-1:0] cls_q, cls_d;

  // Output record register.
  logic out_valid_q;
  out_t out_q;

  logic              emit;
  out_t              rec;
  logic              nedge, checked, complete;
  logic              ge, gt;
  logic [TIME_W-1:0] diff, pw;

  assign pw = (cfg_i.post_window == '0) ? TIME_W'(1) : cfg_i.post_window;

  // One sample's effect on the trial, in the order the rules apply.
  always_comb begin
    open_d   = open_q;
    wover_d  = wover_q;
    hit_d    = hit_q;
    late_d   = late_q;
    prev_n_d = prev_n_q;
    last_d   = last_q;
    stims_d  = stims_q;
    spikes_d = spikes_q;
    cls_d    = cls_q;
    emit     = 1'b0;
    rec      = '0;
    nedge    = 1'b0;
    checked  = 1'b0;

    // Stimulus edge: open, extend, or close and reopen.
    if (head_i.stim_rise && !cfg_i.stop_new_trials) begin
      if (!open_q) begin
        open_d   = 1'b1;
        wover_d  = 1'b0;
        hit_d    = 1'b0;
        late_d   = 1'b0;
        last_d   = head_i.timestamp;
        stims_d  = CNT_W'(1);
        spikes_d = '0;
        cls_d    = head_i.class_id;
      end else if (wover_q) begin
        nedge    = !prev_n_q && head_i.neuron_level;
        prev_n_d = head_i.neuron_level;
        checked  = 1'b1;
        if (nedge) begin
          spikes_d = sat_inc(spikes_q);
          if (!hit_q && !late_q) begin
            late_d = 1'b1;
          end
        end
        emit = 1'b1;
        rec.n_spikes        = spikes_d;
        rec.fired_in_window = hit_d;
        rec.fired_late      = late_d;
        rec.label           = cls_q;
        rec.n_stims         = stims_q;
        rec.closed_time     = head_i.timestamp;
        open_d   = 1'b1;
        wover_d  = 1'b0;
        hit_d    = 1'b0;
        late_d   = 1'b0;
        last_d   = head_i.timestamp;
        stims_d  = CNT_W'(1);
        spikes_d = '0;
        cls_d    = head_i.class_id;
      end else begin
        stims_d = sat_inc(stims_q);
        last_d  = head_i.timestamp;
      end
    end

    // Time since the last stimulus; used only where the timestamp is not below it.
    ge   = head_i.timestamp >= last_d;
    gt   = head_i.timestamp > last_d;
    diff = head_i.timestamp - last_d;
    complete = (stims_d >= CNT_W'(MIN_PATTERN_STIMS)) || (stims_d == CNT_W'(1));

    // Open trial: neuron edge, response flags and window ends.
    if (open_d) begin
      cls_d = head_i.class_id;
      if (!checked) begin
        nedge    = !prev_n_q && head_i.neuron_level;
        prev_n_d = head_i.neuron_level;
      end
      if (nedge) begin
        spikes_d = sat_inc(spikes_d);
      end
      if (!wover_d) begin
        if (nedge && complete && ge && (diff <= pw)) begin
          hit_d = 1'b1;
        end
        if (ge && (diff >= pw)) begin
          wover_d = 1'b1;
          if (hit_d) begin
            emit = 1'b1;
          end else if (nedge && gt && (diff > pw)) begin
            late_d = 1'b1;
          end
        end
      end else if (!hit_d) begin
        if (nedge) begin
          late_d = 1'b1;
        end
        if (ge && (diff >= cfg_i.late_window)) begin
          emit = 1'b1;
        end
      end else if (ge && (diff >= pw)) begin
        emit = 1'b1;
      end
      // A close here records the trial and clears it.
      if (emit && !checked) begin
        rec.n_spikes        = spikes_d;
        rec.fired_in_window = hit_d;
        rec.fired_late      = late_d;
        rec.label           = cls_d;
        rec.n_stims         = stims_d;
        rec.closed_time     = head_i.timestamp;
        open_d   = 1'b0;
        wover_d  = 1'b0;
        hit_d    = 1'b0;
        late_d   = 1'b0;
        last_d   = '0;
        stims_d  = '0;
        spikes_d = '0;
      end
    end
  end

  // Take the head sample unless its record has nowhere to go.
  assign pop_o = !q_stat_i.empty && (!emit || !out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      wover_q  <= 1'b0;
      hit_q    <= 1'b0;
      late_q   <= 1'b0;
      prev_n_q <= 1'b0;
      last_q   <= '0;
      stims_q  <= '0;
      spikes_q <= '0;
      cls_q    <= CLASS_RST;
    end else if (pop_o) begin
      open_q   <= open_d;
      wover_q  <= wover_d;
      hit_q    <= hit_d;
      late_q   <= late_d;
      prev_n_q <= prev_n_d;
      last_q   <= last_d;
      stims_q  <= stims_d;
      spikes_q <= spikes_d;
      cls_q    <= cls_d;
    end
  end

  // Output register: loads a record, empties on a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEVER(a_flags_exclusive, hit_q && late_q, "in-window and late both set")
  `ASSERT_CLK(a_phase_needs_trial, wover_q |-> open_q, "window over without a trial")
  `ASSERT_CLK(a_stims_track_open, open_q == (stims_q != '0), "stimulus count disagrees with trial")
  `ASSERT_CLK(a_no_record_lost, (pop_o && emit) |-> (!out_valid_q || out_ready_i),
    "record written over a pending one")

endmodule

// File: hdl/stimulus_response_trial_tracker.sv
// Top level of the stimulus/response trial tracker: configuration registers,
// front end, queue and back end. Depends on srtt_pkg and its submodules.
//
// The block takes one sample per clock while its queue has room and gives
// one closed-trial record for each trial it closes. A sample passes the front
// end (stimulus edge detect) into a two-entry queue; the back end updates the
// whole trial state for one sample per clock unless it is stalled. A sample is
// registered in the queue, and its record is loaded into the output register
// when the back end takes that sample. The back end stalls only when it must
// emit a record while the output register still holds one that has not been
// taken. Configuration writes take effect at once and are meant to be made
// while the block is idle.
module stimulus_response_trial_tracker import srtt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic              enable_q;
  logic [TIME_W-1:0] post_window_q;
  logic [TIME_W-1:0] late_window_q;
  logic              stop_new_q;
  cfg_t              cfg;

  logic    push, pop;
  item_t   push_item, head;
  q_stat_t q_stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b1;
      post_window_q <= POST_WINDOW_RST;
      late_window_q <= LATE_WINDOW_RST;
      stop_new_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ENABLE:      enable_q      <= cfg_wdata_i[0];
        REG_POST_WINDOW: post_window_q <= cfg_wdata_i[TIME_W-1:0];
        REG_LATE_WINDOW: late_window_q <= cfg_wdata_i[TIME_W-1:0];
        REG_STOP_NEW:    stop_new_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.post_window     = post_window_q;
    cfg.late_window     = late_window_q;
    cfg.stop_new_trials = stop_new_q;
  end

  srtt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (enable_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  srtt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  srtt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
